// ===== sv/hsv2rgb_pkg.sv =====
// Shared constants and types for the HSV to RGB converter.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    localparam int FRACTION_BITS = 12;
    localparam int UNIT_W        = FRACTION_BITS + 1;       // holds 0..1.0
    localparam int ONE_Q         = 1 << FRACTION_BITS;
    localparam int PROD_W        = 2 * UNIT_W;              // v*s plus rounding
    localparam int HUE_W         = 16;
    localparam int SV_W          = 14;
    localparam int TURN_UNITS    = 5760;                    // 360 deg in 1/16 deg
    localparam int SECTOR_UNITS  = 960;                     // 60 deg in 1/16 deg
    localparam int TURN_OFFSET   = 6 * TURN_UNITS;          // makes any hue positive
    localparam int NUM_TURNS     = 11;                      // max whole turns after offset
    localparam int NUM_SECTORS   = 6;
    localparam int WRAP_W        = 17;
    localparam int HW_W          = 13;
    localparam int POS_W         = 10;
    localparam int CT_W          = UNIT_W + POS_W;
    localparam int RECIP_15      = 34953;                   // ceil(2^19 / 15)
    localparam int RECIP_SHIFT   = 19;
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_TDATA_W   = 40;
    localparam int PIPE_DEPTH    = 6;

    typedef enum logic [2:0] {
        SECT_R_TO_Y = 3'd0,
        SECT_Y_TO_G = 3'd1,
        SECT_G_TO_C = 3'd2,
        SECT_C_TO_B = 3'd3,
        SECT_B_TO_M = 3'd4,
        SECT_M_TO_R = 3'd5
    } sector_t;

endpackage

// ===== sv/hsv2rgb_hue.sv =====
// Hue path: wraps the hue into one turn, finds the sector and the ramp position.
`timescale 1ns / 1ps

module hsv2rgb_hue
    import hsv2rgb_pkg::*;
(
    input  logic                    aclk,
    input  logic                    advance,
    input  logic signed [HUE_W-1:0] hue,
    output sector_t                 sector,
    output logic [POS_W-1:0]        ramp
);

    logic [WRAP_W-1:0] shifted;
    logic [WRAP_W-1:0] unwrapped;
    logic [WRAP_W-1:0] turn_off;
    logic [HW_W-1:0]   wrapped_next;
    logic [HW_W-1:0]   wrapped_reg;

    logic [HW_W-1:0]   sect_off;
    sector_t           sect_next;
    logic [POS_W-1:0]  pos_next;
    sector_t           sect_reg;
    logic [POS_W-1:0]  pos_reg;

    logic              odd_sector;
    logic [POS_W-1:0]  ramp_next;
    sector_t           sect_out_reg;
    logic [POS_W-1:0]  ramp_reg;

    // stage 1: true modulus by parallel compares against whole turns
    always_comb begin
        // offset hue is always positive and below 2^WRAP_W
        shifted   = {hue[HUE_W-1], hue} + WRAP_W'(TURN_OFFSET);
        unwrapped = shifted;
        turn_off  = '0;
        for (int k = 1; k <= NUM_TURNS; k++) begin
            if (unwrapped >= WRAP_W'(k * TURN_UNITS)) begin
                turn_off = WRAP_W'(k * TURN_UNITS);
            end
        end
        wrapped_next = HW_W'(unwrapped - turn_off);
    end

    // stage 2: sector index and offset inside the sector
    always_comb begin
        sect_next = SECT_R_TO_Y;
        sect_off  = '0;
        for (int k = 1; k < NUM_SECTORS; k++) begin
            if (wrapped_reg >= HW_W'(k * SECTOR_UNITS)) begin
                sect_next = sector_t'(3'(k));
                sect_off  = HW_W'(k * SECTOR_UNITS);
            end
        end
        pos_next = POS_W'(wrapped_reg - sect_off);
    end

    // stage 3: falling ramp in odd sectors
    assign odd_sector = (sect_reg == SECT_Y_TO_G) || (sect_reg == SECT_C_TO_B) ||
                        (sect_reg == SECT_M_TO_R);
    assign ramp_next  = odd_sector ? POS_W'(SECTOR_UNITS) - pos_reg : pos_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            wrapped_reg  <= wrapped_next;
            sect_reg     <= sect_next;
            pos_reg      <= pos_next;
            sect_out_reg <= sect_reg;
            ramp_reg     <= ramp_next;
        end
    end

    assign sector = sect_out_reg;
    assign ramp   = ramp_reg;

endmodule

// ===== sv/hsv_to_rgb_core.sv =====
// HSV to RGB pixel converter, six-stage pipeline.
// Throughput: one pixel per cycle; the whole pipe holds while m_tready is low
// and m_tvalid is set, and s_tready follows that stall.
// Reset clears the stage valid bits only; data registers are not reset.
`timescale 1ns / 1ps

module hsv_to_rgb_core
    import hsv2rgb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // hue[15:0], saturation[29:16], value[43:30]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // red[12:0], green[25:13], blue[38:26]
);

    logic                    advance;
    logic [PIPE_DEPTH-1:0]   vld_reg;
    logic [PIPE_DEPTH-1:0]   vld_next;

    logic signed [HUE_W-1:0] hue;
    logic signed [SV_W-1:0]  saturation;
    logic signed [SV_W-1:0]  value;

    logic [UNIT_W-1:0]       sat_next;
    logic [UNIT_W-1:0]       val_next;
    logic [UNIT_W-1:0]       sat1_reg;
    logic [UNIT_W-1:0]       val1_reg;

    logic [PROD_W-1:0]       prod2_reg;
    logic [UNIT_W-1:0]       val2_reg;

    logic [PROD_W-1:0]       round3;
    logic [UNIT_W-1:0]       chroma3_reg;
    logic [UNIT_W-1:0]       val3_reg;

    sector_t                 sector3;
    logic [POS_W-1:0]        ramp3;

    logic [CT_W-1:0]         ct4_reg;
    logic [UNIT_W-1:0]       chroma4_reg;
    logic [UNIT_W-1:0]       offs4_reg;
    sector_t                 sect4_reg;

    logic [CT_W-1:0]         ct_round;
    logic [CT_W-7:0]         ct_div64;
    logic [31:0]             recip_prod;
    logic [UNIT_W-1:0]       second5_reg;
    logic [UNIT_W-1:0]       chroma5_reg;
    logic [UNIT_W-1:0]       offs5_reg;
    sector_t                 sect5_reg;

    logic [UNIT_W-1:0]       red_next;
    logic [UNIT_W-1:0]       green_next;
    logic [UNIT_W-1:0]       blue_next;
    logic [UNIT_W-1:0]       red_reg;
    logic [UNIT_W-1:0]       green_reg;
    logic [UNIT_W-1:0]       blue_reg;

    assign advance  = m_tready || !vld_reg[PIPE_DEPTH-1];
    assign s_tready = advance;
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= vld_next;
        end
    end

    assign hue        = signed'(s_tdata[15:0]);
    assign saturation = signed'(s_tdata[29:16]);
    assign value      = signed'(s_tdata[43:30]);

    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [SV_W-1:0] a);
        logic [UNIT_W-1:0] res;
        if (a[SV_W-1]) begin
            res = '0;
        end else if (a > SV_W'(ONE_Q)) begin
            res = UNIT_W'(ONE_Q);
        end else begin
            res = UNIT_W'(a);
        end
        return res;
    endfunction

    assign sat_next = clamp_unit(saturation);
    assign val_next = clamp_unit(value);

    hsv2rgb_hue u_hue (
        .aclk    (aclk),
        .advance (advance),
        .hue     (hue),
        .sector  (sector3),
        .ramp    (ramp3)
    );

    // chroma rounds half up
    assign round3 = prod2_reg + PROD_W'(ONE_Q / 2);

    // x = round(c*t / 960): >>6 then /15 by reciprocal, exact for this range
    assign ct_round   = ct4_reg + CT_W'(SECTOR_UNITS / 2);
    assign ct_div64   = ct_round[CT_W-1:6];
    assign recip_prod = 32'(ct_div64) * 32'(RECIP_15);

    always_comb begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        unique case (sect5_reg)
            SECT_R_TO_Y: begin
                red_next   = chroma5_reg;
                green_next = second5_reg;
            end
            SECT_Y_TO_G: begin
                red_next   = second5_reg;
                green_next = chroma5_reg;
            end
            SECT_G_TO_C: begin
                green_next = chroma5_reg;
                blue_next  = second5_reg;
            end
            SECT_C_TO_B: begin
                green_next = second5_reg;
                blue_next  = chroma5_reg;
            end
            SECT_B_TO_M: begin
                red_next   = second5_reg;
                blue_next  = chroma5_reg;
            end
            SECT_M_TO_R: begin
                red_next   = chroma5_reg;
                blue_next  = second5_reg;
            end
            default: begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sat1_reg    <= sat_next;
            val1_reg    <= val_next;

            prod2_reg   <= PROD_W'(sat1_reg) * PROD_W'(val1_reg);
            val2_reg    <= val1_reg;

            chroma3_reg <= round3[FRACTION_BITS +: UNIT_W];
            val3_reg    <= val2_reg;

            ct4_reg     <= CT_W'(chroma3_reg) * CT_W'(ramp3);
            chroma4_reg <= chroma3_reg;
            offs4_reg   <= val3_reg - chroma3_reg;
            sect4_reg   <= sector3;

            second5_reg <= recip_prod[RECIP_SHIFT +: UNIT_W];
            chroma5_reg <= chroma4_reg;
            offs5_reg   <= offs4_reg;
            sect5_reg   <= sect4_reg;

            red_reg     <= red_next + offs5_reg;
            green_reg   <= green_next + offs5_reg;
            blue_reg    <= blue_next + offs5_reg;
        end
    end

    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_tdata  = {1'b0, blue_reg, green_reg, red_reg};

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the HSV to RGB pixel converter stream core.
`timescale 1ns / 1ps

module tb;
    import hsv2rgb_pkg::*;

    typedef struct {
        logic [UNIT_W-1:0] red;
        logic [UNIT_W-1:0] green;
        logic [UNIT_W-1:0] blue;
    } rgb_t;

    class rgb_scoreboard;
        rgb_t expected_rgb[$];
        int   errors = 0;

        function int clamp_unit(logic signed [SV_W-1:0] q);
            if (q < 0) return 0;
            if (q > ONE_Q) return ONE_Q;
            return int'(q);
        endfunction

        function rgb_t predict_rgb(logic signed [HUE_W-1:0] hue,
                                   logic signed [SV_W-1:0] sat,
                                   logic signed [SV_W-1:0] val);
            int      s, v, hw, f, t, c, x, m, r, g, b;
            sector_t sect;
            rgb_t    p;
            s    = clamp_unit(sat);
            v    = clamp_unit(val);
            hw   = (int'(hue) + TURN_OFFSET) % TURN_UNITS;
            sect = sector_t'(hw / SECTOR_UNITS);
            f    = hw % SECTOR_UNITS;
            // odd sectors ramp x down instead of up
            t    = ((hw / SECTOR_UNITS) % 2 == 1) ? SECTOR_UNITS - f : f;
            c    = (v * s + ONE_Q / 2) >>> FRACTION_BITS;
            x    = (c * t + SECTOR_UNITS / 2) / SECTOR_UNITS;
            m    = v - c;
            case (sect)
                SECT_R_TO_Y: begin r = c; g = x; b = 0; end
                SECT_Y_TO_G: begin r = x; g = c; b = 0; end
                SECT_G_TO_C: begin r = 0; g = c; b = x; end
                SECT_C_TO_B: begin r = 0; g = x; b = c; end
                SECT_B_TO_M: begin r = x; g = 0; b = c; end
                default:     begin r = c; g = 0; b = x; end
            endcase
            p.red   = UNIT_W'(r + m);
            p.green = UNIT_W'(g + m);
            p.blue  = UNIT_W'(b + m);
            return p;
        endfunction

        function void note_pixel(logic [IN_TDATA_W-1:0] d);
            expected_rgb.push_back(predict_rgb(d[15:0], d[29:16], d[43:30]));
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction

        task report_mismatch(string what, logic [UNIT_W-1:0] got, logic [UNIT_W-1:0] want);
            $display("MISMATCH %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_pixel(logic [OUT_TDATA_W-1:0] d);
            rgb_t want;
            if (expected_rgb.size() == 0) begin
                report_mismatch("pixel with no input pending", d[12:0], '0);
                return;
            end
            want = expected_rgb.pop_front();
            if (d[12:0] !== want.red) report_mismatch("red", d[12:0], want.red);
            if (d[25:13] !== want.green) report_mismatch("green", d[25:13], want.green);
            if (d[38:26] !== want.blue) report_mismatch("blue", d[38:26], want.blue);
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // hue[15:0], saturation[29:16], value[43:30]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // red[12:0], green[25:13], blue[38:26]

    rgb_scoreboard sb = new();
    bit            quiet     = 1'b0;   // no idling on either side
    bit            long_hold = 1'b0;   // sink stalls for a long stretch

    hsv_to_rgb_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // transfer monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_pixel(s_tdata);
            if (m_tvalid && m_tready) sb.check_pixel(m_tdata);
        end
    end

    // sink backpressure
    initial begin
        int n;
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready = 1'b0;
                repeat (40) @(negedge aclk);
                m_tready  = 1'b1;
                long_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 3);
                m_tready = 1'b0;
                repeat (n) @(negedge aclk);
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task send_pixel(input logic [HUE_W-1:0] h, input logic [SV_W-1:0] s,
                    input logic [SV_W-1:0] v);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {4'b0, v, s, h};
        do @(posedge aclk); while (!s_tready);
    endtask

    task idle_source(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
    endtask

    task send_random_pixel(input bit gaps);
        int kind, h, s, v;
        if (gaps && !quiet && $urandom_range(0, 4) == 0) idle_source($urandom_range(1, 3));
        kind = $urandom_range(0, 9);
        h = $urandom_range(0, 65535) - 32768;
        if (kind < 6) begin
            // mostly in-range saturation and value
            s = $urandom_range(0, ONE_Q);
            v = $urandom_range(0, ONE_Q);
        end else begin
            s = $urandom_range(0, 16383) - 8192;
            v = $urandom_range(0, 16383) - 8192;
        end
        // hue right around a sector edge, on some random turn
        if (kind == 5 || kind == 9)
            h = $urandom_range(0, 5) * SECTOR_UNITS + $urandom_range(0, 2) - 1
                + TURN_UNITS * ($urandom_range(0, 9) - 5);
        send_pixel(HUE_W'(h), SV_W'(s), SV_W'(v));
    endtask

    task drain_results();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int dir_hue [24] = '{0, -16, -32768, 32767, 959, 960, 1920, 2880, 3840, 4800,
                             5759, 5760, -5760, 480, 480, 480, 480, 1440, 1440, 1440,
                             2400, 3360, 4320, -1};
        int dir_sat [24] = '{4096, 4096, 4096, 4096, 4096, 4096, 4096, 3000, 4096, 2048,
                             4096, 4096, 4096, -8192, 8191, 4097, -1, 4096, 4096, 4096,
                             0, 4096, 1, 8191};
        int dir_val [24] = '{4096, 4096, 4096, 4096, 4096, 4096, 2048, 4096, 4000, 2048,
                             4096, 4096, 4096, 4096, 4096, 4096, 3000, -8192, 8191, 4097,
                             0, 0, 1, 8191};
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_hue[i]) begin
            if ($urandom_range(0, 3) == 0) idle_source($urandom_range(1, 3));
            send_pixel(HUE_W'(dir_hue[i]), SV_W'(dir_sat[i]), SV_W'(dir_val[i]));
        end

        // source waits until the pipe is empty
        idle_source(1);
        drain_results();

        // sink stalls while the source keeps pushing, so the pipe fills
        long_hold = 1'b1;
        repeat (30) send_random_pixel(1'b0);

        repeat (360) send_random_pixel(1'b1);

        quiet = 1'b1;
        repeat (60) send_random_pixel(1'b1);

        idle_source(1);
        drain_results();
        repeat (2 * PIPE_DEPTH) @(posedge aclk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_hue.sv
sv/hsv_to_rgb_core.sv
test/tb.sv
